// ===== hdl/egas_pkg.sv =====
// egas_pkg: shared types and constants for the epsilon-greedy arm selector.
// No dependencies.
package egas_pkg;

   localparam int          SCORE_W    = 64;
   localparam int          COUNT_W    = 32;
   localparam int          VALUE_W    = 31;
   localparam int          MASK_ARMS  = 8;
   localparam logic [30:0] UNSET_VALUE = 31'h7FFF_FFFF;

   localparam logic [1:0] CSR_EXPLORE = 2'd0;
   localparam logic [1:0] CSR_ONCE    = 2'd1;
   localparam logic [1:0] CSR_KIND    = 2'd2;

   localparam logic [1:0] KIND_DIFF  = 2'd0;
   localparam logic [1:0] KIND_REL   = 2'd1;

   typedef struct packed {
      logic [63:0] score;
      logic [31:0] count;
      logic [30:0] best;
      logic [30:0] first;
   } arm_rec_type;

endpackage

// ===== hdl/egas_div.sv =====
// egas_div: restoring divider, one quotient bit per cycle, 64 / 31 bits.
// Depends on egas_pkg.
module egas_div
   import egas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] quo_ff;
   logic [31:0] rem_ff;
   logic [30:0] dvs_ff;
   logic [6:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [32:0] trial;
   logic [31:0] shifted;

   assign shifted = {rem_ff[30:0], quo_ff[63]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 7'd64;
            quo_ff <= dividend;
            rem_ff <= '0;
            dvs_ff <= divisor;
         end else if (run_ff) begin
            if (trial[32]) begin
               rem_ff <= shifted;
               quo_ff <= {quo_ff[62:0], 1'b0};
            end else begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[62:0], 1'b1};
            end
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/epsilon_greedy_arm_selector.sv =====
// epsilon_greedy_arm_selector: top level, arm record memory and sequencer.
// Depends on egas_pkg and egas_div.
//
// One item at a time; busy is high while an item is worked on and start is
// taken only when busy is low. Arm records sit in one synchronous memory
// read one entry per cycle. A pull with an empty mask goes straight to the
// result; a pull scans up to the first min(ARMS, 8) arms. An exploring pull
// first runs the serial remainder of pick_draw by the candidate count; a greedy
// pull reads each compared arm, then does two 32x32 partial-product steps and a
// compare. In relative mode a reward may wait on a one bit per cycle divider.
// The result beat is registered out of the last state, when busy is already
// low. After reset a clearing pass writes every entry, with busy high. Each
// result is a one-cycle beat on rsp_valid; the receiver cannot stall.
module epsilon_greedy_arm_selector
   import egas_pkg::*;
#(
   parameter int ARMS            = 8,
   parameter int SCORE_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_nonempty_mask,
   input  logic [15:0] req_explore_draw,
   input  logic [15:0] req_pick_draw,
   input  logic [30:0] req_heuristic_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_chosen_arm,
   output logic        rsp_arm_valid,
   output logic        rsp_explored,
   output logic        rsp_improved,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam int AW  = $clog2(ARMS);
   localparam int LIM = (ARMS < MASK_ARMS) ? ARMS : MASK_ARMS;
   localparam int IW  = AW + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PRE, S_MOD, S_SCAN_RD, S_SCAN_WT, S_MUL_LO, S_MUL_HI, S_CMP,
      S_RW_RD, S_RW_WT, S_RW_CALC, S_RW_DIV, S_RW_WR, S_DONE
   } state_type;

   state_type   state_ff;
   arm_rec_type mem [ARMS];
   arm_rec_type rd_ff;
   logic        we;
   logic [AW-1:0] wa, ra;
   arm_rec_type wd;

   logic [16:0] eps_ff;
   logic        once_ff;
   logic [1:0]  kind_ff;
   logic [AW-1:0] last_ff;
   logic        pend_ff;

   logic [7:0]  mask_ff;
   logic [15:0] edraw_ff, pdraw_ff;
   logic [30:0] key_ff;
   logic [IW-1:0] idx_ff;
   logic [AW-1:0] best_ff;
   logic [63:0] bscore_ff;
   logic [31:0] bcount_ff;
   logic        found_ff, locked_ff;
   logic [95:0] pa_ff, pb_ff;
   logic [3:0]  cnt_ff;
   logic [3:0]  k_ff;
   logic        explore_ff;
   arm_rec_type rec_ff;
   logic [63:0] add_ff;
   logic        do_add_ff;

   logic        rv_ff, av_ff, ex_ff, im_ff;
   logic [2:0]  ca_ff;

   logic        div_start, div_done;
   logic [63:0] div_q;
   logic [63:0] div_num;

   egas_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(rec_ff.first),
      .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // cross products: score_a*count_b, 32-bit halves
   logic [63:0] m_a, m_b;
   logic [63:0] add_sum;
   logic [64:0] sat_sum;
   logic [63:0] diff_sh;
   assign diff_sh = {33'd0, rec_ff.best - key_ff} << SCORE_FRAC_BITS;
   assign sat_sum = {1'b0, rec_ff.score} + {1'b0, add_ff};
   assign add_sum = sat_sum[64] ? '1 : sat_sum[63:0];
   assign div_num = diff_sh;

   logic [IW-1:0] next_idx;
   assign next_idx = idx_ff + 1'b1;

   always_comb begin
      m_a = (cnt_ff == 4'd0) ? {32'd0, rd_ff.score[31:0]} * {32'd0, bcount_ff}
                             : {32'd0, rd_ff.score[63:32]} * {32'd0, bcount_ff};
      m_b = (cnt_ff == 4'd0) ? {32'd0, bscore_ff[31:0]} * {32'd0, rd_ff.count}
                             : {32'd0, bscore_ff[63:32]} * {32'd0, rd_ff.count};
   end

   always_comb begin
      we = 1'b0;
      wa = last_ff;
      wd = rec_ff;
      ra = idx_ff[AW-1:0];
      div_start = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            wa = idx_ff[AW-1:0];
            wd = '{score: '0, count: '0, best: UNSET_VALUE, first: UNSET_VALUE};
         end
         S_RW_RD: ra = last_ff;
         S_RW_CALC: div_start = (kind_ff == KIND_REL) && do_add_ff
                                && (rec_ff.first != '0);
         S_RW_WR: begin
            we = 1'b1;
            wd = rec_ff;
            if (do_add_ff) wd.score = add_sum;
         end
         default: ;
      endcase
   end

   logic [3:0] cnt_mask;
   always_comb begin
      cnt_mask = '0;
      for (int i = 0; i < LIM; i++) cnt_mask = cnt_mask + {3'd0, mask_ff[i]};
   end

   // restoring remainder step of pick_draw by the candidate count
   logic [3:0] mod_sh;
   assign mod_sh = {k_ff[2:0], pdraw_ff[cnt_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         eps_ff   <= 17'd13107;
         once_ff  <= 1'b0;
         kind_ff  <= '0;
         last_ff  <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_EXPLORE: eps_ff  <= csr_data;
               CSR_ONCE:    once_ff <= csr_data[0];
               CSR_KIND:    kind_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= next_idx;
               if (next_idx == IW'(ARMS)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  mask_ff  <= req_nonempty_mask;
                  edraw_ff <= req_explore_draw;
                  pdraw_ff <= req_pick_draw;
                  key_ff   <= req_heuristic_value;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  locked_ff <= 1'b0;
                  ca_ff <= '0; av_ff <= 1'b0; ex_ff <= 1'b0; im_ff <= 1'b0;
                  state_ff <= req_mode ? S_RW_RD : S_PRE;
               end
            end
            S_PRE: begin
               if (cnt_mask == '0) state_ff <= S_DONE;
               else begin
                  explore_ff <= {1'b0, edraw_ff} < eps_ff;
                  k_ff <= '0;
                  cnt_ff <= 4'd15;
                  state_ff <= ({1'b0, edraw_ff} < eps_ff) ? S_MOD : S_SCAN_RD;
               end
            end
            S_MOD: begin
               k_ff <= (mod_sh >= cnt_mask) ? mod_sh - cnt_mask : mod_sh;
               cnt_ff <= cnt_ff - 4'd1;
               if (cnt_ff == 4'd0) state_ff <= S_SCAN_RD;
            end
            S_SCAN_RD: begin
               if (idx_ff == IW'(LIM)) begin
                  last_ff <= best_ff;
                  pend_ff <= 1'b1;
                  ca_ff <= 3'(best_ff);
                  av_ff <= 1'b1;
                  ex_ff <= explore_ff;
                  state_ff <= S_DONE;
               end else if (!mask_ff[idx_ff[AW-1:0]]) begin
                  idx_ff <= next_idx;
               end else if (explore_ff) begin
                  if (k_ff == '0) begin
                     best_ff <= idx_ff[AW-1:0];
                     idx_ff <= IW'(LIM);
                  end else begin
                     k_ff <= k_ff - 4'd1;
                     idx_ff <= next_idx;
                  end
               end else if (locked_ff) begin
                  idx_ff <= next_idx;
               end else state_ff <= S_SCAN_WT;
            end
            S_SCAN_WT: begin
               if (!found_ff) begin
                  found_ff <= 1'b1;
                  best_ff <= idx_ff[AW-1:0];
                  bscore_ff <= rd_ff.score;
                  bcount_ff <= rd_ff.count;
                  locked_ff <= (rd_ff.count == '0);
                  idx_ff <= next_idx;
                  state_ff <= S_SCAN_RD;
               end else if (rd_ff.count == '0) begin
                  idx_ff <= next_idx;
                  state_ff <= S_SCAN_RD;
               end else begin
                  cnt_ff <= '0;
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               pa_ff <= {32'd0, m_a};
               pb_ff <= {32'd0, m_b};
               cnt_ff <= 4'd1;
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               pa_ff <= pa_ff + {m_a, 32'd0};
               pb_ff <= pb_ff + {m_b, 32'd0};
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (pa_ff > pb_ff) begin
                  best_ff <= idx_ff[AW-1:0];
                  bscore_ff <= rd_ff.score;
                  bcount_ff <= rd_ff.count;
               end
               idx_ff <= next_idx;
               state_ff <= S_SCAN_RD;
            end
            S_RW_RD: state_ff <= S_RW_WT;
            S_RW_WT: begin
               rec_ff <= rd_ff;
               if (!once_ff || pend_ff) begin
                  if (rd_ff.count != '1) rec_ff.count <= rd_ff.count + 32'd1;
                  pend_ff <= 1'b0;
               end
               do_add_ff <= 1'b0;
               if (rd_ff.best > key_ff) begin
                  im_ff <= 1'b1;
                  do_add_ff <= 1'b1;
                  if ((kind_ff == KIND_DIFF || kind_ff == KIND_REL)
                      && rd_ff.best == UNSET_VALUE) begin
                     rec_ff.best <= key_ff;
                     rec_ff.first <= key_ff;
                  end
               end
               state_ff <= S_RW_CALC;
            end
            S_RW_CALC: begin
               if (kind_ff == KIND_DIFF) begin
                  add_ff <= diff_sh;
                  state_ff <= S_RW_WR;
               end else if (kind_ff == KIND_REL) begin
                  add_ff <= '0;
                  state_ff <= (do_add_ff && rec_ff.first != '0) ? S_RW_DIV : S_RW_WR;
               end else begin
                  add_ff <= 64'd1 << SCORE_FRAC_BITS;
                  state_ff <= S_RW_WR;
               end
               if (do_add_ff) rec_ff.best <= key_ff;
            end
            S_RW_DIV: begin
               if (div_done) begin
                  add_ff <= div_q;
                  state_ff <= S_RW_WR;
               end
            end
            S_RW_WR: state_ff <= S_DONE;
            S_DONE: begin
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rv_ff;
   assign rsp_chosen_arm = ca_ff;
   assign rsp_arm_valid  = av_ff;
   assign rsp_explored   = ex_ff;
   assign rsp_improved   = im_ff;

endmodule

// ===== sim/arm_select_checker.sv =====
// arm_select_checker: watches start/busy and rsp beats of the arm selector,
// predicts each result and compares it. Depends on egas_pkg.
`timescale 1ns / 1ps
module arm_select_checker
   import egas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_nonempty_mask,
   input  logic [15:0] req_explore_draw,
   input  logic [15:0] req_pick_draw,
   input  logic [30:0] req_heuristic_value,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_chosen_arm,
   input  logic        rsp_arm_valid,
   input  logic        rsp_explored,
   input  logic        rsp_improved,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   localparam int NARMS = 8;
   localparam int FRAC  = 16;

   typedef struct packed {
      logic [2:0] arm;
      logic       valid;
      logic       explored;
      logic       improved;
   } selection_type;

   logic [63:0] score [NARMS];
   logic [31:0] pulls [NARMS];
   logic [30:0] best  [NARMS];
   logic [30:0] first [NARMS];
   logic [2:0]  last_arm;
   logic        pull_pending;
   logic [16:0] explore_prob;
   logic        once_per_pull;
   logic [1:0]  kind;
   selection_type expected_sel [16];
   logic [3:0]  head_ptr;
   logic [3:0]  tail_ptr;
   int          depth;

   function automatic logic mean_above(int a, int b);
      logic [95:0] pa, pb;
      pa = score[a] * pulls[b];
      pb = score[b] * pulls[a];
      return pa > pb;
   endfunction

   task automatic add_score(int i, logic [63:0] v);
      logic [64:0] s;
      s = score[i] + v;
      score[i] = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endtask

   task automatic predict_beat();
      selection_type r;
      int count, k, chosen, i;
      logic found, locked, explore;
      logic [63:0] diff;
      r = '0;
      if (!req_mode) begin
         count = 0;
         for (i = 0; i < NARMS; i++) count += req_nonempty_mask[i];
         if (count != 0) begin
            explore = {1'b0, req_explore_draw} < explore_prob;
            chosen = 0;
            if (explore) begin
               k = req_pick_draw % count;
               for (i = 0; i < NARMS; i++) begin
                  if (req_nonempty_mask[i]) begin
                     if (k == 0) begin
                        chosen = i;
                        break;
                     end
                     k--;
                  end
               end
            end else begin
               found = 0;
               locked = 0;
               for (i = 0; i < NARMS; i++) begin
                  if (!req_nonempty_mask[i]) continue;
                  if (!found) begin
                     found = 1;
                     chosen = i;
                     locked = pulls[i] == 0;
                  end else if (!locked && pulls[i] != 0 && mean_above(i, chosen)) begin
                     chosen = i;
                  end
               end
            end
            last_arm = chosen[2:0];
            pull_pending = 1;
            r.arm = chosen[2:0];
            r.valid = 1;
            r.explored = explore;
         end
      end else begin
         i = last_arm;
         if (!once_per_pull || pull_pending) begin
            if (pulls[i] != 32'hFFFF_FFFF) pulls[i]++;
            pull_pending = 0;
         end
         if (best[i] > req_heuristic_value) begin
            r.improved = 1;
            if (kind == KIND_DIFF || kind == KIND_REL) begin
               if (best[i] == UNSET_VALUE) begin
                  first[i] = req_heuristic_value;
                  best[i] = req_heuristic_value;
               end
               diff = 64'(best[i] - req_heuristic_value) << FRAC;
               if (kind == KIND_DIFF) add_score(i, diff);
               else if (first[i] != 0) add_score(i, diff / first[i]);
               best[i] = req_heuristic_value;
            end else begin
               best[i] = req_heuristic_value;
               add_score(i, 64'd1 << FRAC);
            end
         end
      end
      expected_sel[tail_ptr] = r;
      tail_ptr++;
      depth++;
   endtask

   always @(posedge clock) begin
      selection_type got, want;
      if (reset) begin
         for (int i = 0; i < NARMS; i++) begin
            score[i] = '0;
            pulls[i] = '0;
            best[i] = UNSET_VALUE;
            first[i] = UNSET_VALUE;
         end
         last_arm = '0;
         pull_pending = 0;
         explore_prob = 17'd13107;
         once_per_pull = 0;
         kind = KIND_DIFF;
         head_ptr = '0;
         tail_ptr = '0;
         depth = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_chosen_arm, rsp_arm_valid, rsp_explored, rsp_improved};
            if (depth == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected beat %p", got);
            end else begin
               want = expected_sel[head_ptr];
               head_ptr++;
               depth--;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("mismatch exp %p got %p", want, got);
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_EXPLORE: explore_prob = csr_data;
               CSR_ONCE:    once_per_pull = csr_data[0];
               CSR_KIND:    kind = csr_data[1:0];
               default: ;
            endcase
         end
         if (start && !busy) predict_beat();
      end
      pending_count = depth;
   end
endmodule

// ===== sim/testbench.sv =====
// testbench: stimulus and verdict for epsilon_greedy_arm_selector.
// Depends on egas_pkg, the block and arm_select_checker.
`timescale 1ns / 1ps
module testbench;
   import egas_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_mode = 0;
   logic [7:0]  req_nonempty_mask = '0;
   logic [15:0] req_explore_draw = '0;
   logic [15:0] req_pick_draw = '0;
   logic [30:0] req_heuristic_value = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_chosen_arm;
   logic        rsp_arm_valid;
   logic        rsp_explored;
   logic        rsp_improved;
   logic        csr_write = 0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   logic        calm = 0;

   always #4 clock = ~clock;

   epsilon_greedy_arm_selector u_dut (.*);
   arm_select_checker u_check (.*);

   always @(posedge clock) begin
      if (start && !busy || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 4000) begin
         $display("FAIL epsilon_greedy_arm_selector");
         $finish;
      end
   end

   task automatic send_beat(logic m, logic [7:0] mk, logic [15:0] ed, logic [15:0] pd,
                            logic [30:0] hv);
      while (!calm && $urandom_range(99) < 23) @(negedge clock);
      req_mode = m;
      req_nonempty_mask = mk;
      req_explore_draw = ed;
      req_pick_draw = pd;
      req_heuristic_value = hv;
      start = 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start = 0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] val);
      csr_write = 1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 0;
   endtask

   function automatic logic [30:0] rand_value();
      case ($urandom_range(3))
         0: return 31'($urandom_range(20));
         1: return 31'($urandom) & 31'h7FFF_FFFE;
         2: return 31'h7FFF_FFFE - 31'($urandom_range(3));
         default: return 31'($urandom_range(100000));
      endcase
   endfunction

   initial begin
      logic [16:0] eps_set [5];
      eps_set = '{17'd0, 17'd65536, 17'd13107, 17'd32768, 17'd131071};
      repeat (2) @(negedge clock);
      reset = 0;
      calm = 1;
      // directed: empty mask, unpulled arms, first improvement, extremes
      send_beat(0, 8'h00, 16'h0000, 16'h0000, 31'd0);
      send_beat(0, 8'hFF, 16'hFFFF, 16'hFFFF, 31'd0);
      send_beat(1, 8'hFF, 16'h0000, 16'h0000, 31'h7FFF_FFFE);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd1000);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd0);
      send_beat(0, 8'h80, 16'h0000, 16'hFFFF, 31'h7FFF_FFFE);
      send_beat(1, 8'h00, 16'hFFFF, 16'h0000, 31'd500);
      send_beat(1, 8'h00, 16'hFFFF, 16'h0000, 31'd10);
      send_beat(0, 8'hFF, 16'hFFFF, 16'h1234, 31'd0);
      send_beat(0, 8'h81, 16'hFFFF, 16'h0000, 31'd0);
      drain();
      write_csr(CSR_KIND, 17'(KIND_REL));
      write_csr(CSR_ONCE, 17'd1);
      send_beat(0, 8'h02, 16'hFFFF, 16'h0000, 31'd0);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd0);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd0);
      send_beat(0, 8'h04, 16'hFFFF, 16'h0000, 31'd0);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd400);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd7);
      drain();
      write_csr(CSR_KIND, 17'd3);
      send_beat(0, 8'h08, 16'hFFFF, 16'h0000, 31'd0);
      send_beat(1, 8'h00, 16'h0000, 16'h0000, 31'd5);
      drain();
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(CSR_EXPLORE, eps_set[ph % 5]);
         write_csr(CSR_ONCE, 17'($urandom_range(1)));
         write_csr(CSR_KIND, 17'($urandom_range(3)));
         calm = (ph == 3);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(9) < 9) begin
               send_beat(0, $urandom_range(9) == 0 ? 8'h00 : 8'($urandom),
                         16'($urandom), 16'($urandom), 31'($urandom));
               repeat ($urandom_range(2)) send_beat(1, 8'($urandom), 16'($urandom),
                                                   16'($urandom), rand_value());
            end else begin
               send_beat(1, 8'($urandom), 16'($urandom), 16'($urandom), rand_value());
            end
            if (n == 25) drain();
         end
         drain();
      end
      if (fail_count == 0) $display("PASS epsilon_greedy_arm_selector");
      else $display("FAIL epsilon_greedy_arm_selector");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/egas_pkg.sv
hdl/egas_div.sv
hdl/epsilon_greedy_arm_selector.sv
sim/arm_select_checker.sv
sim/testbench.sv
